// ===== rtl/ipsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsd_pkg
// Types and constants shared by the incremental PID speed drive.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsd_pkg;

  localparam int unsigned SPEED_W = 15;
  localparam int unsigned GAIN_W  = 7;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned DELTA2_W = 18;
  localparam int unsigned PROD_W  = 26;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned DRIVE_W = 16;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 7'd10;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 7'd1;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 7'd1;
  localparam logic [SPEED_W-1:0] DEAD_BAND_RST = 15'd0;
  localparam logic [SPEED_W-1:0] LIMIT_RST     = 15'd32767;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEAD_BAND = 3'd3,
    REG_LIMIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] dead_band;
    logic [SPEED_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] target_speed;
    logic [SPEED_W-1:0] measured_speed;
  } in_beat_t;

  typedef struct packed {
    logic [SPEED_W-1:0]        forward_duty;
    logic [SPEED_W-1:0]        reverse_duty;
    logic signed [DRIVE_W-1:0] drive_signed;
    logic                      in_dead_band;
  } out_beat_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]    err;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [DELTA2_W-1:0] delta2;
    logic                       in_band;
  } err_beat_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_prop;
    logic signed [PROD_W-1:0] p_int;
    logic signed [PROD_W-1:0] p_der;
    logic                     in_band;
  } prod_beat_t;

endpackage

`default_nettype wire

// ===== rtl/ipsd_cfg.sv =====
// ----------------------------------------------------------------------------
// ipsd_cfg
// APB register file holding gains, dead band and drive limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsd_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ipsd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ipsd_pkg::APB_DW-1:0]  pwdata,
  output logic      [ipsd_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output ipsd_pkg::cfg_t                    cfg_o
);

  ipsd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= ipsd_pkg::GAIN_P_RST;
      cfg_q.gain_i    <= ipsd_pkg::GAIN_I_RST;
      cfg_q.gain_d    <= ipsd_pkg::GAIN_D_RST;
      cfg_q.dead_band <= ipsd_pkg::DEAD_BAND_RST;
      cfg_q.limit     <= ipsd_pkg::LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ipsd_pkg::REG_GAIN_P:    cfg_q.gain_p    <= pwdata[ipsd_pkg::GAIN_W-1:0];
        ipsd_pkg::REG_GAIN_I:    cfg_q.gain_i    <= pwdata[ipsd_pkg::GAIN_W-1:0];
        ipsd_pkg::REG_GAIN_D:    cfg_q.gain_d    <= pwdata[ipsd_pkg::GAIN_W-1:0];
        ipsd_pkg::REG_DEAD_BAND: cfg_q.dead_band <= pwdata[ipsd_pkg::SPEED_W-1:0];
        ipsd_pkg::REG_LIMIT:     cfg_q.limit     <= pwdata[ipsd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ipsd_pkg::REG_GAIN_P:    prdata[ipsd_pkg::GAIN_W-1:0]  = cfg_q.gain_p;
      ipsd_pkg::REG_GAIN_I:    prdata[ipsd_pkg::GAIN_W-1:0]  = cfg_q.gain_i;
      ipsd_pkg::REG_GAIN_D:    prdata[ipsd_pkg::GAIN_W-1:0]  = cfg_q.gain_d;
      ipsd_pkg::REG_DEAD_BAND: prdata[ipsd_pkg::SPEED_W-1:0] = cfg_q.dead_band;
      ipsd_pkg::REG_LIMIT:     prdata[ipsd_pkg::SPEED_W-1:0] = cfg_q.limit;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/ipsd_err.sv =====
// ----------------------------------------------------------------------------
// ipsd_err
// Input register, error differences, dead band test and error history.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsd_err (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ipsd_pkg::SPEED_W-1:0]  dead_band_i,
  input  wire logic                          up_valid_i,
  output logic                               up_stall_o,
  input  wire ipsd_pkg::in_beat_t            up_data_i,
  output logic                               dn_valid_o,
  input  wire logic                          dn_stall_i,
  output ipsd_pkg::err_beat_t                dn_data_o
);

  logic                                     valid_q;
  ipsd_pkg::in_beat_t                       beat_q;
  logic signed [ipsd_pkg::ERR_W-1:0]        last_err_q;
  logic signed [ipsd_pkg::DELTA_W-1:0]      last_delta_q;
  logic signed [ipsd_pkg::ERR_W-1:0]        err;
  logic        [ipsd_pkg::ERR_W-1:0]        mag;
  logic                                     leave;

  assign up_stall_o = valid_q && dn_stall_i;
  assign leave      = valid_q && !dn_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && !up_stall_o) begin
      beat_q <= up_data_i;
    end
  end

  always_comb begin
    err = $signed({1'b0, beat_q.target_speed}) - $signed({1'b0, beat_q.measured_speed});
    mag = err[ipsd_pkg::ERR_W-1] ? ipsd_pkg::ERR_W'(-err) : ipsd_pkg::ERR_W'(err);
    dn_data_o.err     = err;
    dn_data_o.delta   = ipsd_pkg::DELTA_W'(err) - ipsd_pkg::DELTA_W'(last_err_q);
    dn_data_o.delta2  = ipsd_pkg::DELTA2_W'(dn_data_o.delta)
                      - ipsd_pkg::DELTA2_W'(last_delta_q);
    dn_data_o.in_band = mag < {1'b0, dead_band_i};
  end

  // history moves on only when the beat leaves, so order is kept under stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q   <= '0;
      last_delta_q <= '0;
    end else if (leave) begin
      last_err_q   <= dn_data_o.err;
      last_delta_q <= dn_data_o.delta;
    end
  end

  assign dn_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/ipsd_mul.sv =====
// ----------------------------------------------------------------------------
// ipsd_mul
// Error register and the three gain products.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsd_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ipsd_pkg::cfg_t cfg_i,
  input  wire logic          up_valid_i,
  output logic               up_stall_o,
  input  wire ipsd_pkg::err_beat_t up_data_i,
  output logic               dn_valid_o,
  input  wire logic          dn_stall_i,
  output ipsd_pkg::prod_beat_t dn_data_o
);

  logic                valid_q;
  ipsd_pkg::err_beat_t beat_q;

  assign up_stall_o = valid_q && dn_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && !up_stall_o) begin
      beat_q <= up_data_i;
    end
  end

  always_comb begin
    dn_data_o.p_prop  = ipsd_pkg::PROD_W'($signed({1'b0, cfg_i.gain_p}))
                      * ipsd_pkg::PROD_W'(beat_q.delta);
    dn_data_o.p_int   = ipsd_pkg::PROD_W'($signed({1'b0, cfg_i.gain_i}))
                      * ipsd_pkg::PROD_W'(beat_q.err);
    dn_data_o.p_der   = ipsd_pkg::PROD_W'($signed({1'b0, cfg_i.gain_d}))
                      * ipsd_pkg::PROD_W'(beat_q.delta2);
    dn_data_o.in_band = beat_q.in_band;
  end

  assign dn_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/ipsd_acc.sv =====
// ----------------------------------------------------------------------------
// ipsd_acc
// Product register, increment sum, drive accumulate and clamp, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsd_acc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ipsd_pkg::SPEED_W-1:0]  limit_i,
  input  wire logic                          up_valid_i,
  output logic                               up_stall_o,
  input  wire ipsd_pkg::prod_beat_t          up_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ipsd_pkg::out_beat_t                out_data_o
);

  logic                                  valid_q;
  ipsd_pkg::prod_beat_t                  beat_q;
  logic                                  out_valid_q;
  ipsd_pkg::out_beat_t                   out_q;
  ipsd_pkg::out_beat_t                   out_d;
  logic signed [ipsd_pkg::DRIVE_W-1:0]   drive_q;
  logic signed [ipsd_pkg::DRIVE_W-1:0]   drive_d;
  logic signed [ipsd_pkg::DRIVE_W-1:0]   drive_neg;
  logic signed [ipsd_pkg::SUM_W-1:0]     inc;
  logic signed [ipsd_pkg::SUM_W-1:0]     level;
  logic signed [ipsd_pkg::SUM_W-1:0]     lim_pos;
  logic signed [ipsd_pkg::SUM_W-1:0]     lim_neg;
  logic                                  out_hold;
  logic                                  load_out;

  assign out_hold   = out_valid_q && out_stall_i;
  assign up_stall_o = valid_q && out_hold;
  assign load_out   = valid_q && !out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && !up_stall_o) begin
      beat_q <= up_data_i;
    end
  end

  always_comb begin
    lim_pos = $signed({{(ipsd_pkg::SUM_W-ipsd_pkg::SPEED_W){1'b0}}, limit_i});
    lim_neg = -lim_pos;
    if (beat_q.in_band) begin
      inc = '0;
    end else begin
      inc = ipsd_pkg::SUM_W'(beat_q.p_prop) + ipsd_pkg::SUM_W'(beat_q.p_int)
          + ipsd_pkg::SUM_W'(beat_q.p_der);
    end
    level = ipsd_pkg::SUM_W'(drive_q) + inc;
    if (level > lim_pos) begin
      drive_d = lim_pos[ipsd_pkg::DRIVE_W-1:0];
    end else if (level < lim_neg) begin
      drive_d = lim_neg[ipsd_pkg::DRIVE_W-1:0];
    end else begin
      drive_d = level[ipsd_pkg::DRIVE_W-1:0];
    end
    drive_neg = -drive_d;
    out_d.forward_duty = (drive_d > 0) ? drive_d[ipsd_pkg::SPEED_W-1:0] : '0;
    out_d.reverse_duty = (drive_d < 0) ? drive_neg[ipsd_pkg::SPEED_W-1:0] : '0;
    out_d.drive_signed = drive_d;
    out_d.in_dead_band = beat_q.in_band;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drive_q     <= '0;
    end else begin
      if (!out_hold) begin
        out_valid_q <= valid_q;
      end
      if (load_out) begin
        drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/incremental_pid_speed_drive.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_speed_drive
// Velocity-form PID speed loop with dead band and clamped drive level.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid_i/in_stall_o   ipsd_pkg::in_beat_t
//  out      output     out_valid_o/out_stall_i ipsd_pkg::out_beat_t
//  cfg      input      APB psel/penable/pwrite  5 registers at 4*index
//
//  four register stages: input, differences, products, result
//  one beat per cycle sustained while out_stall_i is low
//  the drive level loop closes in the accumulate stage through drive_q
//  reset clears gains to defaults, histories and drive level to zero
//  a stalled result holds; upstream stages keep filling until full
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_speed_drive (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ipsd_pkg::in_beat_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ipsd_pkg::out_beat_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ipsd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ipsd_pkg::APB_DW-1:0]   pwdata,
  output logic      [ipsd_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  ipsd_pkg::cfg_t       cfg;
  logic                 err_valid;
  logic                 err_stall;
  ipsd_pkg::err_beat_t  err_beat;
  logic                 prod_valid;
  logic                 prod_stall;
  ipsd_pkg::prod_beat_t prod_beat;

  ipsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ipsd_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dead_band_i (cfg.dead_band),
    .up_valid_i  (in_valid_i),
    .up_stall_o  (in_stall_o),
    .up_data_i   (in_data_i),
    .dn_valid_o  (err_valid),
    .dn_stall_i  (err_stall),
    .dn_data_o   (err_beat)
  );

  ipsd_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (err_valid),
    .up_stall_o (err_stall),
    .up_data_i  (err_beat),
    .dn_valid_o (prod_valid),
    .dn_stall_i (prod_stall),
    .dn_data_o  (prod_beat)
  );

  ipsd_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (cfg.limit),
    .up_valid_i  (prod_valid),
    .up_stall_o  (prod_stall),
    .up_data_i   (prod_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
